/* src/bsws_pkg.sv */
// Shared types and constants for the bucketed sliding window sum core.
package bsws_pkg;

    localparam int NUM_W    = 24;
    localparam int TS_W     = 32;
    localparam int CELL_W   = 32;
    localparam int SUM_W    = 37;
    localparam int NBUCKETS = 32;
    localparam int SLOT_W   = $clog2(NBUCKETS);
    localparam int CNT_W    = SLOT_W + 1;

    localparam logic FUNC_HIT   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [TS_W-1:0]          timestamp;
        logic signed [CELL_W-1:0] amount;
    } t_in;

    typedef struct packed {
        logic signed [SUM_W-1:0] window_sum;
        logic                    applied;
    } t_out;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic                 is_query;
        logic                 query_empty;
        logic                 new_interval;
        logic [NUM_W-1:0]     num;
        logic [CELL_W-1:0]    amount;
    } t_cmd;

endpackage

/* src/bsws_front.sv */
// Front end: takes requests, divides the timestamp into a bucket number.
module bsws_front import bsws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [NUM_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_cmd              o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state                r_state;
    logic [NUM_W-1:0]      r_cfg;
    logic [NUM_W-1:0]      r_iv_used;
    logic [NUM_W-1:0]      r_div;
    logic [NUM_W-1:0]      r_rem;
    logic [TS_W-1:0]       r_quo;
    logic [CNT_W-1:0]      r_step;
    logic                  r_query;
    logic                  r_empty;
    logic                  r_newint;
    logic [CELL_W-1:0]     r_amt;

    logic [NUM_W-1:0]      iv_cfg;
    logic [NUM_W:0]        trial;
    logic                  fits;
    logic                  accept;

    assign iv_cfg = (r_cfg == '0) ? NUM_W'(1) : r_cfg;
    assign trial  = {r_rem, r_quo[TS_W-1]};
    assign fits   = trial >= {1'b0, r_div};
    assign accept = i_in_valid && (r_state == S_IDLE);

    assign o_in_stall = (r_state != S_IDLE);
    assign o_q_push   = (r_state == S_PUSH) && !i_q_full;

    assign o_cmd.is_query     = r_query;
    assign o_cmd.query_empty  = r_empty;
    assign o_cmd.new_interval = r_newint;
    assign o_cmd.num          = r_quo[NUM_W-1:0];
    assign o_cmd.amount       = r_amt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= NUM_W'(1);
            r_iv_used <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_query <= (i_in.func == FUNC_QUERY);
                        r_amt   <= i_in.amount;
                        r_quo   <= i_in.timestamp;
                        r_rem   <= '0;
                        r_step  <= CNT_W'(TS_W);
                        if (i_in.func == FUNC_QUERY) begin
                            // query uses the interval the buckets were built with
                            r_div    <= (r_iv_used == '0) ? NUM_W'(1) : r_iv_used;
                            r_empty  <= (r_iv_used == '0);
                            r_newint <= 1'b0;
                        end else begin
                            r_div     <= iv_cfg;
                            r_empty   <= 1'b0;
                            r_newint  <= (r_iv_used != iv_cfg);
                            r_iv_used <= iv_cfg;
                        end
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= fits ? NUM_W'(trial - {1'b0, r_div}) : trial[NUM_W-1:0];
                    r_quo  <= {r_quo[TS_W-2:0], fits};
                    r_step <= r_step - CNT_W'(1);
                    if (r_step == CNT_W'(1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* src/bsws_queue.sv */
// Two-entry queue between the front and the back.
module bsws_queue import bsws_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    input  t_cmd  i_cmd,
    output t_cmd  o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_pop && !o_empty) ? 1 : 0);
        end
    end

endmodule

/* src/bsws_back.sv */
// Back end: clears, writes and sums the bucket ring, holds the result.
module bsws_back import bsws_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_empty,
    output logic  o_q_pop,
    input  t_cmd  i_cmd,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_out  o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLEAR = 5'b00010,
        S_WRITE = 5'b00100,
        S_SUM   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state             r_state;
    logic [CELL_W-1:0]  r_store [NBUCKETS];
    logic [NUM_W-1:0]   r_last;
    logic [SLOT_W-1:0]  r_ptr;
    logic [SLOT_W-1:0]  r_slot;
    logic [CNT_W-1:0]   r_cnt;
    logic [CELL_W-1:0]  r_amt;
    logic               r_set;
    logic               r_applied;
    logic [SUM_W-1:0]   r_acc;

    logic [NUM_W-1:0]   diff;
    logic               d_pos;
    logic               d_big;
    logic               do_set;
    logic               do_add;
    logic [CNT_W-1:0]   clr_cnt;
    logic [CNT_W-1:0]   q_cnt;
    logic [CELL_W-1:0]  bucket_val;

    assign diff    = i_cmd.num - r_last;
    assign d_pos   = !diff[NUM_W-1] && (diff != '0);
    assign d_big   = !diff[NUM_W-1] && (diff[NUM_W-2:SLOT_W] != '0);
    assign do_set  = i_cmd.new_interval || d_pos;
    assign do_add  = !do_set && ((diff == '0) ||
                     (diff[NUM_W-1] && (diff >= NUM_W'(-(NBUCKETS - 1)))));
    assign clr_cnt = (i_cmd.new_interval || d_big) ? CNT_W'(NBUCKETS)
                                                   : diff[CNT_W-1:0];
    // negative difference counts as zero: the whole ring
    assign q_cnt   = diff[NUM_W-1] ? CNT_W'(NBUCKETS)
                                   : CNT_W'(NBUCKETS) - diff[CNT_W-1:0];
    assign bucket_val = r_store[r_ptr];

    assign o_q_pop            = (r_state == S_IDLE) && !i_q_empty;
    assign o_out_valid        = (r_state == S_OUT);
    assign o_out.window_sum   = r_acc;
    assign o_out.applied      = r_applied;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= '0;
            for (int i = 0; i < NBUCKETS; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_acc   <= '0;
                        r_slot  <= i_cmd.num[SLOT_W-1:0];
                        r_amt   <= i_cmd.amount;
                        r_set   <= do_set;
                        if (i_cmd.is_query) begin
                            r_applied <= 1'b0;
                            r_ptr     <= r_last[SLOT_W-1:0];
                            r_cnt     <= q_cnt;
                            if (i_cmd.query_empty || d_big) begin
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_SUM;
                            end
                        end else begin
                            r_applied <= do_set || do_add;
                            if (do_set) begin
                                r_ptr   <= i_cmd.num[SLOT_W-1:0];
                                r_cnt   <= clr_cnt;
                                r_last  <= i_cmd.num;
                                r_state <= S_CLEAR;
                            end else if (do_add) begin
                                r_state <= S_WRITE;
                            end else begin
                                r_ptr   <= '0;
                                r_cnt   <= CNT_W'(NBUCKETS);
                                r_state <= S_SUM;
                            end
                        end
                    end
                end
                S_CLEAR: begin
                    r_store[r_ptr] <= '0;
                    r_ptr <= r_ptr - SLOT_W'(1);
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_store[r_slot] <= r_set ? r_amt : r_store[r_slot] + r_amt;
                    r_ptr   <= '0;
                    r_cnt   <= CNT_W'(NBUCKETS);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    // walk down the ring, sign-extend each bucket
                    r_acc <= r_acc + {{(SUM_W-CELL_W){bucket_val[CELL_W-1]}}, bucket_val};
                    r_ptr <= r_ptr - SLOT_W'(1);
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* src/bucketed_sliding_window_sum_core.sv */
// Top level of the bucketed sliding window sum core.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid/o_in_stall   i_in  (t_in)
//   out      output     o_out_valid/i_out_stall o_out (t_out)
//   cfg      input      i_cfg_we                i_cfg_data (bucket interval)
//
// The front does a serial divide of the timestamp by the bucket interval.
// The back walks the 32-bucket ring: it pops a request, clears the buckets that a newer
// bucket number moves past, writes the hit into its bucket, sums the ring and holds the
// result; a query skips the clear and the write.
// A two-entry queue lets the front divide the next request while the back works.
// Reset is synchronous and clears the ring, the interval in use and the queue.
// A stalled result holds in the back and stops it; the front keeps going until the
// queue fills, then stalls the input.
module bucketed_sliding_window_sum_core import bsws_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [NUM_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out
);

    t_cmd  front_cmd;
    t_cmd  back_cmd;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;

    bsws_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_cmd      (front_cmd)
    );

    bsws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_cmd   (front_cmd),
        .o_cmd   (back_cmd)
    );

    bsws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_cmd       (back_cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
